@@ src/jsu_pkg.sv @@
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

  // Result status codes
  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_BADHEX  = 3'd3;
  localparam logic [2:0] ST_ENDED   = 3'd4;

  localparam int RUN_DEPTH = 4;
  localparam int RUN_AW    = $clog2(RUN_DEPTH);

  // All results caused by one input byte, as handed from front to back.
  typedef struct packed {
    logic [1:0] cnt;     // number of results, 1 to 3
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [2:0] status;
  } run_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ src/jsu_front.sv @@
// Front end: accepts text bytes, tracks decode mode and builds result runs.
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          end_of_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  jsu_pkg::q_stat_t q_stat,
  output logic          push,
  output jsu_pkg::run_t run
);

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_STR  = 2'd1,
    M_ESC  = 2'd2,
    M_HEX  = 2'd3
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [11:0] code_point, code_point_next;

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;
  logic        is_space;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp       = {code_point, hex_val};
  assign is_space = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0A) ||
                    (in_byte == 8'h0D) || (in_byte == 8'h0C) || (in_byte == 8'h0B);

  always_comb begin
    mode_next       = mode;
    hex_cnt_next    = hex_cnt;
    code_point_next = code_point;
    run             = '0;
    run.cnt         = 2'd1;
    run.status      = jsu_pkg::ST_BYTE;
    push            = 1'b0;
    if (end_of_data) begin
      push            = 1'b1;
      run.status      = jsu_pkg::ST_ENDED;
      mode_next       = M_IDLE;
      hex_cnt_next    = 2'd0;
      code_point_next = '0;
    end else begin
      case (mode)
        M_IDLE: begin
          if (in_byte == 8'h22) begin
            mode_next = M_STR;
          end else if (!is_space) begin
            push       = 1'b1;
            run.status = jsu_pkg::ST_NOQUOTE;
          end
        end
        M_STR: begin
          if (in_byte == 8'h5C) begin
            mode_next = M_ESC;
          end else if (in_byte == 8'h22) begin
            push       = 1'b1;
            run.status = jsu_pkg::ST_CLOSED;
            mode_next  = M_IDLE;
          end else begin
            push   = 1'b1;
            run.b0 = in_byte;
          end
        end
        M_ESC: begin
          mode_next = M_STR;
          push      = 1'b1;
          case (in_byte)
            8'h62:   run.b0 = 8'h08;  // b
            8'h66:   run.b0 = 8'h0C;  // f
            8'h6E:   run.b0 = 8'h0A;  // n
            8'h72:   run.b0 = 8'h0D;  // r
            8'h74:   run.b0 = 8'h09;  // t
            8'h75: begin             // u: start hex digits
              push            = 1'b0;
              mode_next       = M_HEX;
              hex_cnt_next    = 2'd0;
              code_point_next = '0;
            end
            default: run.b0 = in_byte;
          endcase
        end
        M_HEX: begin
          if (!hex_ok) begin
            push            = 1'b1;
            run.status      = jsu_pkg::ST_BADHEX;
            mode_next       = M_IDLE;
            hex_cnt_next    = 2'd0;
            code_point_next = '0;
          end else if (hex_cnt == 2'd3) begin
            push = 1'b1;
            if (cp[15:7] == '0) begin
              run.b0 = {1'b0, cp[6:0]};
            end else if (cp[15:11] == '0) begin
              run.cnt = 2'd2;
              run.b0  = {3'b110, cp[10:6]};
              run.b1  = {2'b10, cp[5:0]};
            end else begin
              run.cnt = 2'd3;
              run.b0  = {4'b1110, cp[15:12]};
              run.b1  = {2'b10, cp[11:6]};
              run.b2  = {2'b10, cp[5:0]};
            end
            mode_next       = M_STR;
            hex_cnt_next    = 2'd0;
            code_point_next = '0;
          end else begin
            hex_cnt_next    = hex_cnt + 2'd1;
            code_point_next = cp[11:0];
          end
        end
        default: mode_next = M_IDLE;
      endcase
    end
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      hex_cnt    <= 2'd0;
      code_point <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_cnt    <= hex_cnt_next;
      code_point <= code_point_next;
    end
  end

endmodule

@@ src/jsu_fifo.sv @@
// Short queue of result runs between front and back.
module jsu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::run_t    wr_run,
  input  logic             pop,
  output jsu_pkg::run_t    head,
  output jsu_pkg::q_stat_t q_stat
);

  jsu_pkg::run_t mem [jsu_pkg::RUN_DEPTH];

  logic [jsu_pkg::RUN_AW-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::RUN_AW:0]   count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == (jsu_pkg::RUN_AW+1)'(jsu_pkg::RUN_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/jsu_back.sv @@
// Back end: unrolls each run into single results through an output register.
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::run_t    head,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic [7:0]       out_byte,
  output logic [2:0]       status,
  output logic             last_of_run,
  output logic             out_valid,
  input  logic             out_stall
);

  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       is_last;
  logic [7:0] sel;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_stat.empty;
  assign is_last = (idx == head.cnt - 2'd1);
  assign pop     = take && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel = head.b0;
      2'd1:    sel = head.b1;
      2'd2:    sel = head.b2;
      default: sel = head.b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        out_byte    <= sel;
        status      <= head.status;
        last_of_run <= is_last;
        idx         <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

@@ src/json_string_unescaper.sv @@
// Top level of the streaming JSON string unescaper.
//
// Input channel: in_byte / end_of_data with in_valid and in_stall. One text
// byte (or an end-of-data mark) is transferred per cycle when in_valid is
// high and in_stall low. Output channel: out_byte / status / last_of_run
// with out_valid and out_stall; one result per transfer, last_of_run marks
// the final result caused by an input byte.
//
// A byte's run is written into the queue at its transfer; its first result
// then reaches the outputs when the output register loads it from the
// queue. Plain text is taken at one input byte per cycle while in_stall is low;
// a byte can make up to three results (for a \uXXXX escape), and the
// output register drains one result per cycle while out_stall is low.
// Whitespace before the opening quote, the opening quote, an escaping
// backslash, the u of \uXXXX and hex digits before the last make none.
//
// A four-entry queue of runs sits between the decoder and the output
// stage; in_stall rises only when it is full, so a stalled receiver backs
// up the queue first. Reset (rst, synchronous) returns the decoder to idle
// and empties the queue and the output register.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       last_of_run,
  output logic       out_valid,
  input  logic       out_stall
);

  jsu_pkg::run_t    wr_run;
  jsu_pkg::run_t    head;
  jsu_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  // Decoder: one byte per transfer, emits a run for bytes that make results
  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .end_of_data (end_of_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .q_stat      (q_stat),
    .push        (push),
    .run         (wr_run)
  );

  jsu_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_run (wr_run),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Output stage: one result per cycle from the head run while out_stall is low
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_byte    (out_byte),
    .status      (status),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule
